// File: rtl/core/line_end_brake_controller_defines.svh
// Assertion macros for the line end brake controller checks.
// Each macro expects clk and rst_n in scope.
`ifndef LINE_END_BRAKE_CONTROLLER_DEFINES_SVH
`define LINE_END_BRAKE_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define LBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;

    // Sensor lanes
    localparam int NUM_SENSORS = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int SUM_W       = SAMPLE_BITS + $clog2(NUM_SENSORS);

    // Encoder and ramp arithmetic widths
    localparam int PULSE_W   = 32;
    localparam int TRAVEL_W  = PULSE_W + 1;
    localparam int REM_W     = PULSE_W + 2;
    localparam int DUTY_W    = 16;
    localparam int DIVISOR_W = 16;
    localparam int PROD_W    = 50;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd4;

    // Modes as reported on the result
    localparam logic [1:0] MODE_FOLLOWING = 2'd0;
    localparam logic [1:0] MODE_BRAKING   = 2'd1;
    localparam logic [1:0] MODE_STOPPED   = 2'd2;

    localparam logic [DUTY_W-1:0] NEUTRAL_DUTY = 16'h8000;
    localparam logic [3:0]        DARK_RUN_MAX = 4'd15;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]    sample_0;
        logic [SAMPLE_BITS-1:0]    sample_1;
        logic [SAMPLE_BITS-1:0]    sample_2;
        logic [SAMPLE_BITS-1:0]    sample_3;
        logic [SAMPLE_BITS-1:0]    sample_4;
        logic [SAMPLE_BITS-1:0]    sample_5;
        logic signed [PULSE_W-1:0] left_pulses;
        logic signed [PULSE_W-1:0] right_pulses;
    } tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_duty;
        logic [1:0]        mode;
    } result_t;

endpackage

// File: rtl/core/lbc_sense.sv
`timescale 1ns / 1ps
// Sensor lanes plus merge: each lane holds one sample, the merge sums them.
module lbc_sense
    import lbc_pkg::*;
(
    input  logic                                   clk,
    input  logic                                   capture,
    input  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples,
    output logic [SUM_W-1:0]                       sum
);

    logic [SAMPLE_BITS-1:0] lane_reg [NUM_SENSORS];
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       sum_reg;

    // One capture register per sensor lane
    for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
        always_ff @(posedge clk)
        begin
            if (capture)
            begin
                lane_reg[i] <= samples[i];
            end
        end
    end

    // Merge stage: sum of all lanes, registered
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sum_next = sum_next + SUM_W'(lane_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// File: rtl/core/lbc_enc_lane.sv
`timescale 1ns / 1ps
// Encoder lane: holds the latched count and the wrapped travel since it.
module lbc_enc_lane
    import lbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capture,
    input  logic               latch,
    input  logic [PULSE_W-1:0] pulses,
    output logic [PULSE_W-1:0] diff
);

    logic [PULSE_W-1:0] latch_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic [PULSE_W-1:0] diff_reg;

    // Latched count is state and resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
        end
        else if (latch)
        begin
            latch_reg <= pulse_reg;
        end
    end

    // Count of the current item and its wrapped difference (mod 2^32)
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            pulse_reg <= pulses;
            diff_reg  <= pulses - latch_reg;
        end
    end

    assign diff = diff_reg;

endmodule

// File: rtl/core/lbc_div.sv
`timescale 1ns / 1ps
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module lbc_div
    import lbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [PROD_W-1:0]    quotient
);

    localparam int STEPS = PROD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [PROD_W-1:0]    quo_next;

    // Two restoring steps; quo shifts dividend bits out and quotient bits in
    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        logic [DIVISOR_W:0] diff;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_next, quo_next[PROD_W-1]};
            diff     = trial - {1'b0, dsr_reg};
            quo_next = {quo_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = diff[DIVISOR_W-1:0];
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/line_end_brake_controller.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload   Direction
// tick     tick_valid/tick_ready  tick_t    in: samples and encoder counts
// res      res_valid/res_ready    result_t  out: drive duty and mode
// cfg      cfg_we                 cfg_index, cfg_wdata  in: register writes
//
// One item at a time. Following, stopped and end-of-braking items pass through
// ST_SUM, ST_DECIDE and ST_OUT; a braking ramp item also takes two multiplier passes
// for the ramp numerator, ST_MUL_ADD, the 25-step radix-4 divider and ST_FIN.
// A new item is accepted while a finished result waits in the output register.
// Reset (rst_n low, async) restores register defaults and the following mode.
module line_end_brake_controller
    import lbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    output logic                 tick_ready,
    input  tick_t                tick,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int SPEED_W = 20;
    localparam int QM_W    = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DECIDE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ADD,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    // Duty = neutral - speed, saturated to 0..neutral
    function automatic logic [DUTY_W-1:0] sat_duty(input logic [SPEED_W-1:0] speed);
        logic signed [SPEED_W:0] d;
        d = $signed({{(SPEED_W + 1 - DUTY_W){1'b0}}, NEUTRAL_DUTY})
            - $signed({speed[SPEED_W-1], speed});
        if (d < 0)
            sat_duty = '0;
        else if (d > $signed({{(SPEED_W + 1 - DUTY_W){1'b0}}, NEUTRAL_DUTY}))
            sat_duty = NEUTRAL_DUTY;
        else
            sat_duty = d[DUTY_W-1:0];
    endfunction

    state_t               state_reg;
    logic [14:0]          thr_reg;
    logic [3:0]           confirm_reg;
    logic [DUTY_W-1:0]    sdc_reg;
    logic [DUTY_W-1:0]    bs_reg;
    logic [DUTY_W-1:0]    ms_reg;
    logic [1:0]           mode_reg;
    logic [3:0]           dark_run_reg;
    logic [DUTY_W-1:0]    last_duty_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic signed [REM_W-1:0] rem_reg;
    logic [32:0]          plo_reg;
    logic [32:0]          phi_reg;
    logic                 res_valid_reg;
    result_t              res_reg;

    logic                 accept;
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples;
    logic [SUM_W-1:0]     sum;
    logic [PULSE_W-1:0]   diff_l;
    logic [PULSE_W-1:0]   diff_r;
    logic                 latch;
    logic [TRAVEL_W-1:0]  travel;
    logic [REM_W-1:0]     rem_next;
    logic                 dark;
    logic [3:0]           run_next;
    logic                 confirmed;
    logic [DUTY_W:0]      delta;
    logic [DUTY_W-1:0]    abs_delta;
    logic                 rem_pos;
    logic [16:0]          mul_a;
    logic [32:0]          mul_p;
    logic [PROD_W-1:0]    dividend;
    logic                 div_start;
    logic                 div_done;
    logic [PROD_W-1:0]    quotient;
    logic                 q_big;
    logic [SPEED_W-1:0]   q_s;
    logic [SPEED_W-1:0]   ramp_speed;
    logic [DUTY_W-1:0]    ramp_duty;
    logic [DUTY_W-1:0]    cruise_duty;

    assign accept     = tick_valid && tick_ready;
    assign tick_ready = (state_reg == ST_IDLE);
    assign samples    = {tick.sample_5, tick.sample_4, tick.sample_3,
                         tick.sample_2, tick.sample_1, tick.sample_0};

    // Sensor lanes and merge
    lbc_sense u_sense (
        .clk     (clk),
        .capture (accept),
        .samples (samples),
        .sum     (sum)
    );

    // Encoder lanes
    lbc_enc_lane u_enc_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (accept),
        .latch   (latch),
        .pulses  (tick.left_pulses),
        .diff    (diff_l)
    );

    lbc_enc_lane u_enc_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (accept),
        .latch   (latch),
        .pulses  (tick.right_pulses),
        .diff    (diff_r)
    );

    // Remaining travel = stop distance - (dL + dR)
    assign travel   = {diff_l[PULSE_W-1], diff_l} + {diff_r[PULSE_W-1], diff_r};
    assign rem_next = {{(REM_W - DUTY_W){1'b0}}, sdc_reg} - {travel[TRAVEL_W-1], travel};
    assign rem_pos  = !rem_reg[REM_W-1] && (rem_reg != '0);

    // Dark run tracking
    assign dark      = 32'(sum) < 32'(thr_reg);
    assign run_next  = !dark ? 4'd0 :
                       (dark_run_reg == DARK_RUN_MAX) ? dark_run_reg : dark_run_reg + 4'd1;
    assign confirmed = run_next >= confirm_reg;
    assign latch     = (state_reg == ST_DECIDE) && (mode_reg == MODE_FOLLOWING) && confirmed;

    // Ramp slope magnitude
    assign delta     = {1'b0, bs_reg} - {1'b0, ms_reg};
    assign abs_delta = delta[DUTY_W] ? 16'(-delta) : delta[DUTY_W-1:0];

    // Shared multiplier: low 17 bits of rem, then high 16 bits
    assign mul_a    = (state_reg == ST_MUL_LO) ? rem_reg[16:0] : {1'b0, rem_reg[32:17]};
    assign mul_p    = {16'b0, mul_a} * {17'b0, abs_delta};
    assign dividend = {{(PROD_W - 33){1'b0}}, plo_reg} + {phi_reg, 17'b0};
    assign div_start = (state_reg == ST_MUL_ADD);

    lbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (sdc_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Speed = min + signed quotient; large quotients saturate the duty directly
    assign q_big      = |quotient[PROD_W-1:QM_W];
    assign q_s        = delta[DUTY_W] ? -{2'b0, quotient[QM_W-1:0]} : {2'b0, quotient[QM_W-1:0]};
    assign ramp_speed = {{(SPEED_W - DUTY_W){1'b0}}, ms_reg} + q_s;
    assign ramp_duty  = q_big ? (delta[DUTY_W] ? NEUTRAL_DUTY : '0) : sat_duty(ramp_speed);
    assign cruise_duty = sat_duty({{(SPEED_W - DUTY_W){1'b0}}, bs_reg});

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= 15'd410;
            confirm_reg <= 4'd1;
            sdc_reg     <= 16'd1655;
            bs_reg      <= 16'd26214;
            ms_reg      <= 16'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DARK_THRESHOLD: thr_reg     <= cfg_wdata[14:0];
                REG_CONFIRM_TICKS:  confirm_reg <= cfg_wdata[3:0];
                REG_STOP_DISTANCE:  sdc_reg     <= cfg_wdata;
                REG_BRAKE_SPEED:    bs_reg      <= cfg_wdata;
                REG_MIN_SPEED:      ms_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control sequencer, mode state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FOLLOWING;
            dark_run_reg  <= '0;
            last_duty_reg <= '0;
            duty_reg      <= '0;
            rem_reg       <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // Result taken; ST_OUT refills the register itself on the same edge
            if (res_valid_reg && res_ready && (state_reg != ST_OUT))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    rem_reg   <= $signed(rem_next);
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    unique case (mode_reg)
                        MODE_FOLLOWING:
                        begin
                            dark_run_reg <= run_next;
                            if (confirmed)
                            begin
                                mode_reg <= MODE_BRAKING;
                                duty_reg <= last_duty_reg;
                            end
                            else
                            begin
                                duty_reg      <= cruise_duty;
                                last_duty_reg <= cruise_duty;
                            end
                            state_reg <= ST_OUT;
                        end
                        MODE_BRAKING:
                        begin
                            if (!rem_pos)
                            begin
                                mode_reg      <= MODE_STOPPED;
                                duty_reg      <= NEUTRAL_DUTY;
                                last_duty_reg <= NEUTRAL_DUTY;
                                state_reg     <= ST_OUT;
                            end
                            else if (sdc_reg == '0)
                            begin
                                // zero stop distance: speed is the brake speed
                                duty_reg      <= cruise_duty;
                                last_duty_reg <= cruise_duty;
                                state_reg     <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_MUL_LO;
                            end
                        end
                        default:
                        begin
                            mode_reg      <= MODE_STOPPED;
                            duty_reg      <= NEUTRAL_DUTY;
                            last_duty_reg <= NEUTRAL_DUTY;
                            state_reg     <= ST_OUT;
                        end
                    endcase
                end
                ST_MUL_LO:
                begin
                    plo_reg   <= mul_p;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    phi_reg   <= mul_p;
                    state_reg <= ST_MUL_ADD;
                end
                ST_MUL_ADD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    duty_reg      <= ramp_duty;
                    last_duty_reg <= ramp_duty;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_reg.drive_duty <= duty_reg;
                        res_reg.mode       <= mode_reg;
                        res_valid_reg      <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/core/lbc_checker.sv
`timescale 1ns / 1ps
`include "line_end_brake_controller_defines.svh"
// Port-level checks for the line end brake controller.
module lbc_checker
    import lbc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 tick_valid,
    input logic                 tick_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input result_t              res,
    input logic                 cfg_we
);

    logic stopped_seen_reg;

    // Remember that a stopped result has been delivered since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_seen_reg <= 1'b0;
        end
        else if (res_valid && res_ready && (res.mode == MODE_STOPPED))
        begin
            stopped_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds
    `LBC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

    // One item in flight: no accept directly after an accept
    `LBC_ASSERT_NXT(a_one_item, tick_valid && tick_ready, !tick_ready, "item accepted back to back")

    // Stopped is final until reset, and always neutral
    `LBC_ASSERT_IMP(a_stop_final, res_valid && stopped_seen_reg, (res.mode == MODE_STOPPED) && (res.drive_duty == NEUTRAL_DUTY), "left stopped mode")

    // Duty never exceeds neutral; checked while no register write is in progress
    `LBC_ASSERT_IMP(a_duty_range, res_valid && !cfg_we, res.drive_duty <= NEUTRAL_DUTY, "duty above neutral")

endmodule

bind line_end_brake_controller lbc_checker u_lbc_checker (.*);

// File: tb/line_end_brake_controller_tb.sv
`timescale 1ns / 1ps
module line_end_brake_controller_tb;
    import lbc_pkg::*;

    localparam longint HALF_RANGE = 64'sd2147483648;
    localparam int unsigned MAX_SUM = 24570;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 tick_valid = 1'b0;
    logic                 tick_ready;
    tick_t                tick = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    result_t              res;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow copy of the registers and of the controller state
    logic [14:0] thr_cfg;
    logic [3:0]  confirm_cfg;
    logic [15:0] stop_cfg;
    logic [15:0] brake_cfg;
    logic [15:0] minspd_cfg;
    logic [1:0]  mode_q;
    logic [3:0]  dark_run_q;
    logic [31:0] latch_l_q;
    logic [31:0] latch_r_q;
    logic [15:0] last_duty_q;

    result_t duty_expect_q[$];
    int      sent_n = 0;
    int      checked_n = 0;
    int      err_n = 0;
    int      hold_left = 0;
    int      follow_n = 0;
    int      braking_n = 0;
    int      stopped_n = 0;

    line_end_brake_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_valid(tick_valid),
        .tick_ready(tick_ready),
        .tick      (tick),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Duty = neutral minus speed, clamped to 0..neutral
    function automatic logic [15:0] clamp_duty(input longint speed);
        longint d;
        d = 64'sd32768 - speed;
        if (d < 0)
            d = 0;
        if (d > 64'sd32768)
            d = 64'sd32768;
        return d[15:0];
    endfunction

    // Advance the shadow state by one tick and return the expected result
    function automatic result_t brake_law(input tick_t t);
        result_t            r;
        logic [15:0]        sum;
        logic signed [31:0] dl;
        logic signed [31:0] dr;
        longint             travel;
        longint             rem;
        longint             delta;
        longint             q;
        sum = 16'(t.sample_0) + 16'(t.sample_1) + 16'(t.sample_2)
            + 16'(t.sample_3) + 16'(t.sample_4) + 16'(t.sample_5);
        if (mode_q == MODE_FOLLOWING) begin
            if (sum < 16'(thr_cfg)) begin
                if (dark_run_q < DARK_RUN_MAX)
                    dark_run_q = dark_run_q + 4'd1;
            end
            else
                dark_run_q = '0;
            if (dark_run_q >= confirm_cfg) begin
                latch_l_q = t.left_pulses;
                latch_r_q = t.right_pulses;
                mode_q = MODE_BRAKING;
                r.drive_duty = last_duty_q;
            end
            else
                r.drive_duty = clamp_duty(longint'(brake_cfg));
        end
        else if (mode_q == MODE_BRAKING) begin
            dl = t.left_pulses - latch_l_q;
            dr = t.right_pulses - latch_r_q;
            travel = longint'(dl) + longint'(dr);
            rem = longint'(stop_cfg) - travel;
            if (rem <= 0) begin
                r.drive_duty = NEUTRAL_DUTY;
                mode_q = MODE_STOPPED;
            end
            else begin
                delta = longint'(brake_cfg) - longint'(minspd_cfg);
                // zero stop distance holds the ramp at its start
                if (stop_cfg == 16'd0)
                    q = delta;
                else
                    q = (rem * delta) / longint'(stop_cfg);
                r.drive_duty = clamp_duty(longint'(minspd_cfg) + q);
            end
        end
        else begin
            r.drive_duty = NEUTRAL_DUTY;
            mode_q = MODE_STOPPED;
        end
        r.mode = mode_q;
        last_duty_q = r.drive_duty;
        return r;
    endfunction

    // Build a tick whose six samples add up to the given total
    function automatic tick_t make_tick(input int unsigned total, input logic [31:0] l,
                                        input logic [31:0] r);
        tick_t       t;
        int unsigned left_over;
        int unsigned lo;
        int unsigned hi;
        int unsigned s;
        logic [11:0] v[6];
        left_over = total;
        for (int i = 0; i < 6; i++)
        begin
            hi = (left_over > 4095) ? 4095 : left_over;
            lo = (left_over > 4095 * (5 - i)) ? left_over - 4095 * (5 - i) : 0;
            s = $urandom_range(hi, lo);
            v[i] = s[11:0];
            left_over = left_over - s;
        end
        t.sample_0 = v[0];
        t.sample_1 = v[1];
        t.sample_2 = v[2];
        t.sample_3 = v[3];
        t.sample_4 = v[4];
        t.sample_5 = v[5];
        t.left_pulses = l;
        t.right_pulses = r;
        return t;
    endfunction

    // Following tick, dark or bright against the current threshold
    function automatic tick_t cruise_tick(input bit dark);
        int unsigned total;
        if (dark)
            total = $urandom_range(0, thr_cfg - 1);
        else
            total = $urandom_range(thr_cfg, MAX_SUM);
        return make_tick(total, $urandom, $urandom);
    endfunction

    // Braking tick whose summed travel since the latch equals total
    function automatic tick_t travel_tick(input longint total);
        longint          lo;
        longint          hi;
        longint          dl;
        longint          dr;
        longint unsigned span;
        lo = (total - (HALF_RANGE - 1) > -HALF_RANGE) ? total - (HALF_RANGE - 1) : -HALF_RANGE;
        hi = (total + HALF_RANGE < HALF_RANGE - 1) ? total + HALF_RANGE : HALF_RANGE - 1;
        span = longint'(hi - lo + 1);
        dl = lo + longint'({$urandom, $urandom} % span);
        dr = total - dl;
        return make_tick($urandom_range(0, MAX_SUM), latch_l_q + dl[31:0],
                         latch_r_q + dr[31:0]);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DARK_THRESHOLD: thr_cfg = val[14:0];
            REG_CONFIRM_TICKS:  confirm_cfg = val[3:0];
            REG_STOP_DISTANCE:  stop_cfg = val;
            REG_BRAKE_SPEED:    brake_cfg = val;
            REG_MIN_SPEED:      minspd_cfg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one item, with sender gaps by run stage, and record its result
    task automatic send_tick(input tick_t t);
        int gap_pct;
        gap_pct = (sent_n < 630) ? 11 : (sent_n < 1260) ? 85 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        duty_expect_q.push_back(brake_law(t));
        sent_n++;
    endtask

    // Block idle: no item offered, every result back, pipeline drained
    task automatic settle();
        tick_valid <= 1'b0;
        while (duty_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Threshold boundaries, sample and encoder extremes, cruise saturation
    task automatic check_following_edges();
        settle();
        write_reg(REG_CONFIRM_TICKS, 16'd15);
        send_tick(make_tick(MAX_SUM, 32'h0000_0000, 32'h0000_0000));
        send_tick(make_tick(0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_tick(make_tick(409, 32'hFFFF_FFFF, 32'h0000_0000));
        send_tick(make_tick(410, 32'h8000_0000, 32'h7FFF_FFFF));
        settle();
        write_reg(REG_DARK_THRESHOLD, 16'd24570);
        send_tick(make_tick(24569, $urandom, $urandom));
        send_tick(make_tick(MAX_SUM, $urandom, $urandom));
        settle();
        write_reg(REG_DARK_THRESHOLD, 16'd0);
        send_tick(make_tick(0, $urandom, $urandom));
        settle();
        // threshold above the largest sum: everything is dark
        write_reg(REG_DARK_THRESHOLD, 16'd32767);
        send_tick(make_tick(MAX_SUM, $urandom, $urandom));
        settle();
        write_reg(REG_DARK_THRESHOLD, 16'd410);
        write_reg(REG_BRAKE_SPEED, 16'd0);
        send_tick(cruise_tick(1'b0));
        settle();
        write_reg(REG_BRAKE_SPEED, 16'd32768);
        send_tick(cruise_tick(1'b0));
        settle();
        write_reg(REG_BRAKE_SPEED, 16'hFFFF);
        write_reg(REG_CONFIRM_TICKS, 16'd1);
        send_tick(cruise_tick(1'b0));
    endtask

    // Random dark runs kept one short of the confirm count
    task automatic check_cruise_random();
        bit dark;
        for (int k = 0; k < 6; k++)
        begin
            settle();
            write_reg(REG_DARK_THRESHOLD,
                      (k == 5) ? 16'd24570 : 16'($urandom_range(1, MAX_SUM)));
            write_reg(REG_CONFIRM_TICKS,
                      (k == 0) ? 16'd15 : (k == 1) ? 16'd2 : 16'($urandom_range(2, 15)));
            write_reg(REG_BRAKE_SPEED, (k == 2) ? 16'hFFFF : 16'($urandom_range(0, 32768)));
            repeat (90)
            begin
                dark = ($urandom_range(99) < 45) && (dark_run_q + 5'd1 < 5'(confirm_cfg));
                send_tick(cruise_tick(dark));
            end
        end
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic check_output_backpressure();
        hold_left = 300;
        repeat (12) send_tick(cruise_tick(1'b0));
    endtask

    // Reset is applied once, so the run sees a single end of line, here
    task automatic check_line_end_detect();
        settle();
        write_reg(REG_DARK_THRESHOLD, 16'd2000);
        write_reg(REG_CONFIRM_TICKS, 16'd4);
        write_reg(REG_BRAKE_SPEED, 16'd20000);
        send_tick(cruise_tick(1'b0));
        repeat (3) send_tick(cruise_tick(1'b1));
        send_tick(make_tick(1999, $urandom, $urandom));
    endtask

    // Ramp over many register settings; remaining travel is kept positive
    task automatic check_brake_ramp();
        int unsigned stop_set[7]  = '{1655, 65535, 1, 0, 1000, 40000, 500};
        int unsigned brake_set[7] = '{26214, 32768, 32768, 20000, 5000, 65535, 0};
        int unsigned min_set[7]   = '{6554, 0, 32768, 5000, 30000, 0, 65535};
        longint      s;
        longint      total;
        for (int k = 0; k < 13; k++)
        begin
            settle();
            if (k < 7) begin
                write_reg(REG_STOP_DISTANCE, 16'(stop_set[k]));
                write_reg(REG_BRAKE_SPEED, 16'(brake_set[k]));
                write_reg(REG_MIN_SPEED, 16'(min_set[k]));
            end
            else begin
                write_reg(REG_STOP_DISTANCE, 16'($urandom_range(0, 65535)));
                write_reg(REG_BRAKE_SPEED, 16'($urandom_range(0, 32768)));
                write_reg(REG_MIN_SPEED, 16'($urandom_range(0, 32768)));
            end
            s = longint'(stop_cfg);
            if (k == 0) begin
                // one count left, no travel, full backward travel, wrapped split
                send_tick(travel_tick(s - 1));
                send_tick(travel_tick(0));
                send_tick(travel_tick(-2 * HALF_RANGE));
                send_tick(make_tick(100, latch_l_q + 32'h7FFF_FFFF, latch_r_q + 32'h8000_0000));
            end
            repeat (100)
            begin
                case ($urandom_range(9))
                    6: total = s - 1;
                    7, 8: total = -longint'($urandom) - 1;
                    9: total = s - 1 - longint'($urandom_range(0, 255));
                    default: total = s - 1 - longint'($urandom_range(0, stop_cfg + 2000));
                endcase
                send_tick(travel_tick(total));
            end
        end
    endtask

    // Travel reaches the stop distance, then the duty stays neutral
    task automatic check_stop_hold();
        send_tick(travel_tick(longint'(stop_cfg)));
        repeat (40) send_tick(make_tick($urandom_range(0, MAX_SUM), $urandom, $urandom));
    endtask

    // Receiver: random stalls by run stage, plus a long hold on request
    always @(posedge clk)
    begin : recv_side
        int stall_pct;
        stall_pct = (sent_n < 630) ? 85 : (sent_n < 1260) ? 11 : 0;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_valid && res_ready) begin
            if (duty_expect_q.size() == 0) begin
                $error("unexpected result: drive_duty %0d mode %0d", res.drive_duty, res.mode);
                err_n++;
            end
            else begin
                want = duty_expect_q.pop_front();
                checked_n++;
                if (want.mode == MODE_FOLLOWING)
                    follow_n++;
                else if (want.mode == MODE_BRAKING)
                    braking_n++;
                else
                    stopped_n++;
                if (res.drive_duty !== want.drive_duty) begin
                    $error("drive_duty: expected %0d, got %0d", want.drive_duty, res.drive_duty);
                    err_n++;
                end
                if (res.mode !== want.mode) begin
                    $error("mode: expected %0d, got %0d", want.mode, res.mode);
                    err_n++;
                end
            end
        end
    end

    initial
    begin : run_tests
        int waited;
        thr_cfg = 15'd410;
        confirm_cfg = 4'd1;
        stop_cfg = 16'd1655;
        brake_cfg = 16'd26214;
        minspd_cfg = 16'd6554;
        mode_q = MODE_FOLLOWING;
        dark_run_q = '0;
        latch_l_q = '0;
        latch_r_q = '0;
        last_duty_q = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_following_edges();
        check_cruise_random();
        check_output_backpressure();
        check_line_end_detect();
        check_brake_ramp();
        check_stop_hold();

        // drain, then allow for the longest ramp item
        tick_valid <= 1'b0;
        waited = 0;
        while (duty_expect_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (duty_expect_q.size() != 0) begin
            $error("%0d results never arrived", duty_expect_q.size());
            err_n++;
        end

        $display("%0d ticks sent, %0d results checked, %0d mismatches",
                 sent_n, checked_n, err_n);
        $display("following %0d, braking ramp %0d, stopped %0d ticks",
                 follow_n, braking_n, stopped_n);
        if (err_n == 0)
            $display("line_end_brake_controller_tb: done, clean");
        else
            $display("line_end_brake_controller_tb: done, errors");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("line_end_brake_controller_tb: done, errors");
        $finish;
    end

endmodule
